### sv/rgbhsv_pkg.sv
`default_nettype none

package rgbhsv_pkg;

  localparam int CHAN_W      = 8;
  localparam int DIFF_W      = CHAN_W + 1;
  localparam int SAT_DVD_W   = 2 * CHAN_W;
  localparam int M_W         = CHAN_W + 3;
  localparam int HUE_DVD_W   = M_W + 6;
  localparam int HUE_DIV_W   = CHAN_W + 1;
  localparam int DIV_STAGES  = CHAN_W;
  localparam int FRONT_STAGES = 3;
  localparam int NUM_STAGES  = FRONT_STAGES + DIV_STAGES;

  // hue byte = floor(m * 85 / (2 * delta)), m = hue * delta / 60
  localparam logic [HUE_DVD_W-1:0] HUE_MUL = HUE_DVD_W'(85);
  localparam logic [2:0] OFF_RED_WRAP = 3'd6;
  localparam logic [2:0] OFF_GREEN    = 3'd2;
  localparam logic [2:0] OFF_BLUE     = 3'd4;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sect_t;

  typedef struct packed {
    logic [CHAN_W-1:0]        mx;
    logic [CHAN_W-1:0]        delta;
    logic signed [DIFF_W-1:0] diff;
    sect_t                    sect;
  } s1_t;

  typedef struct packed {
    logic [CHAN_W-1:0]    mx;
    logic [CHAN_W-1:0]    delta;
    logic [SAT_DVD_W-1:0] sat_dvd;
    logic [M_W-1:0]       m;
  } s2_t;

  typedef struct packed {
    logic [CHAN_W-1:0]    mx;
    logic [CHAN_W-1:0]    delta;
    logic [SAT_DVD_W-1:0] sat_dvd;
    logic [HUE_DVD_W-1:0] hue_dvd;
  } s3_t;

  typedef struct packed {
    logic [CHAN_W-1:0]    value;
    logic                 zero;
    logic [SAT_DVD_W-1:0] rs;
    logic [HUE_DVD_W-1:0] rh;
    logic [CHAN_W-1:0]    ds;
    logic [HUE_DIV_W-1:0] dh;
    logic [CHAN_W-1:0]    qs;
    logic [CHAN_W-1:0]    qh;
  } div_t;

endpackage

`default_nettype wire

### sv/rgb_to_hsv_pixel.sv
// channel | direction | handshake            | fields
// input   | in        | in_valid / in_stall  | red, green, blue
// output  | out       | out_valid / out_stall| value_out, saturation_out, hue_out
//
// one pixel per clock when the output is not stalled
// three front stages (max/min, sector offset, hue scale) then an eight-stage
// restoring divide, one quotient bit per stage for saturation and hue
// reset clears only the stage valid bits
// a stage holds while it and every stage after it are full and out_stall is high; empty stages fill
`default_nettype none

module rgb_to_hsv_pixel import rgbhsv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAN_W-1:0] red,
  input  wire logic [CHAN_W-1:0] green,
  input  wire logic [CHAN_W-1:0] blue,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CHAN_W-1:0]      value_out,
  output logic [CHAN_W-1:0]      saturation_out,
  output logic [CHAN_W-1:0]      hue_out
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  s3_t  s3;
  div_t dfeed;
  div_t dr [DIV_STAGES];
  div_t dn [DIV_STAGES];

  logic [CHAN_W-1:0] mx_c, mn_c;
  logic [2:0]        off;
  logic [M_W-1:0]    offd;
  logic signed [M_W+1:0] m_wide;

  // stall chain
  assign adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end
  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: max, min, sector, signed difference
  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c)  mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c)  mn_c = blue;
    s1_next.mx    = mx_c;
    s1_next.delta = mx_c - mn_c;
    priority if (red == mx_c) begin
      s1_next.sect = SECT_RED;
      s1_next.diff = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green == mx_c) begin
      s1_next.sect = SECT_GREEN;
      s1_next.diff = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      s1_next.sect = SECT_BLUE;
      s1_next.diff = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1 <= s1_next;
    end
  end

  // stage 2: sector offset, saturation dividend
  always_comb begin
    unique case (s1.sect)
      SECT_RED:   off = s1.diff[DIFF_W-1] ? OFF_RED_WRAP : 3'd0;
      SECT_GREEN: off = OFF_GREEN;
      SECT_BLUE:  off = OFF_BLUE;
      default:    off = 3'd0;
    endcase
    offd   = M_W'(off) * M_W'(s1.delta);
    m_wide = $signed({2'b00, offd}) + (M_W+2)'(s1.diff);
    s2_next.mx      = s1.mx;
    s2_next.delta   = s1.delta;
    s2_next.sat_dvd = {s1.delta, CHAN_W'(0)} - SAT_DVD_W'(s1.delta);
    s2_next.m       = m_wide[M_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2 <= s2_next;
    end
  end

  // stage 3: hue dividend
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3.mx      <= s2.mx;
      s3.delta   <= s2.delta;
      s3.sat_dvd <= s2.sat_dvd;
      s3.hue_dvd <= HUE_DVD_W'(s2.m) * HUE_MUL;
    end
  end

  always_comb begin
    dfeed.value = s3.mx;
    dfeed.zero  = (s3.delta == '0);
    dfeed.rs    = s3.sat_dvd;
    dfeed.rh    = s3.hue_dvd;
    dfeed.ds    = s3.mx;
    dfeed.dh    = {s3.delta, 1'b0};
    dfeed.qs    = '0;
    dfeed.qh    = '0;
  end

  // restoring divide, msb first
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int Sh = DIV_STAGES - 1 - j;
    div_t src;
    logic [SAT_DVD_W-1:0] ts;
    logic [HUE_DVD_W-1:0] th;

    if (j == 0) begin : g_first
      assign src = dfeed;
    end else begin : g_rest
      assign src = dr[j-1];
    end

    assign ts = SAT_DVD_W'(src.ds) << Sh;
    assign th = HUE_DVD_W'(src.dh) << Sh;

    always_comb begin
      dn[j] = src;
      if (src.rs >= ts) begin
        dn[j].rs     = src.rs - ts;
        dn[j].qs[Sh] = 1'b1;
      end
      if (src.rh >= th) begin
        dn[j].rh     = src.rh - th;
        dn[j].qh[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[FRONT_STAGES + j]) begin
        dr[j] <= dn[j];
      end
    end
  end

  assign out_valid      = vld[NUM_STAGES-1];
  assign value_out      = dr[DIV_STAGES-1].value;
  assign saturation_out = dr[DIV_STAGES-1].zero ? '0 : dr[DIV_STAGES-1].qs;
  assign hue_out        = dr[DIV_STAGES-1].zero ? '0 : dr[DIV_STAGES-1].qh;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted request did not enter stage one");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output stage");

  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_out == '0 |-> saturation_out == '0 && hue_out == '0)
    else $error("black pixel gave nonzero saturation or hue");

  a_sat_needs_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturation_out != '0 |-> value_out != '0 && hue_out <= 8'd254)
    else $error("saturation or hue out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

### tb/rgb_to_hsv_pixel_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_tb;
  import rgbhsv_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int FLUSH_CYCLES = 40;

  typedef struct packed {
    logic [CHAN_W-1:0] value;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] hue;
  } hsv_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic out_valid;
  logic out_stall;
  logic [CHAN_W-1:0] value_out;
  logic [CHAN_W-1:0] saturation_out;
  logic [CHAN_W-1:0] hue_out;

  hsv_t hsv_due[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  rgb_to_hsv_pixel DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value_out(value_out),
    .saturation_out(saturation_out),
    .hue_out(hue_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic hsv_t hsv_of(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                  logic [CHAN_W-1:0] b);
    int ri, gi, bi, mx, mn, delta, num;
    sect_t sect;
    hsv_t res;
    ri = r;
    gi = g;
    bi = b;
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    delta = mx - mn;
    res.value = CHAN_W'(mx);
    res.sat = '0;
    res.hue = '0;
    if (mx != 0 && delta != 0) begin
      res.sat = CHAN_W'((delta * 255) / mx);
      // ties go red first, then green
      if (ri == mx) sect = SECT_RED;
      else if (gi == mx) sect = SECT_GREEN;
      else sect = SECT_BLUE;
      case (sect)
        SECT_RED: begin
          num = 60 * (gi - bi);
          if (num < 0) num += 360 * delta;
        end
        SECT_GREEN: num = 120 * delta + 60 * (bi - ri);
        default: num = 240 * delta + 60 * (ri - gi);
      endcase
      res.hue = CHAN_W'((num * 255) / (360 * delta));
    end
    return res;
  endfunction

  task automatic send_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                            logic [CHAN_W-1:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (in_stall);
    hsv_due.push_back(hsv_of(r, g, b));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (hsv_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd1, 8'd255);
  endtask

  task automatic test_sectors();
    // tied maxima
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd100);
    // red sector, with and without negative hue wrapping
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd254);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd10, 8'd3, 8'd9);
    // green and blue sectors both ways
    send_pixel(8'd0, 8'd255, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd254, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd254, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd171);
  endtask

  task automatic send_random_pixel();
    logic [CHAN_W-1:0] c[3];
    int kind, mx, lo, base, i;
    kind = $urandom_range(0, 9);
    case (kind)
      5: begin
        c[0] = CHAN_W'($urandom_range(0, 255));
        c[1] = c[0];
        c[2] = c[0];
      end
      6: begin
        mx = $urandom_range(1, 255);
        lo = $urandom_range(0, mx);
        i = $urandom_range(0, 2);
        c[0] = CHAN_W'(mx);
        c[1] = CHAN_W'(mx);
        c[2] = CHAN_W'(mx);
        c[i] = CHAN_W'(lo);
      end
      7: begin
        base = $urandom_range(2, 253);
        for (i = 0; i < 3; i++) c[i] = CHAN_W'(base + $urandom_range(0, 4) - 2);
      end
      8: begin
        for (i = 0; i < 3; i++) c[i] = CHAN_W'($urandom);
        i = $urandom_range(0, 2);
        c[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      9: begin
        c[0] = 8'd255;
        c[1] = 8'd0;
        c[2] = CHAN_W'($urandom);
        for (i = 2; i > 0; i--) begin
          base = $urandom_range(0, i);
          {c[i], c[base]} = {c[base], c[i]};
        end
      end
      default: for (i = 0; i < 3; i++) c[i] = CHAN_W'($urandom);
    endcase
    send_pixel(c[0], c[1], c[2]);
  endtask

  task automatic test_random(int count);
    repeat (count) send_random_pixel();
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(5, 12)) send_random_pixel();
      wait_drained();
    end
  endtask

  task automatic test_full_rate(int count);
    idle_on = 1'b0;
    repeat (count) send_random_pixel();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    red <= '0;
    green <= '0;
    blue <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_sectors();
    test_random(650);
    test_drain_pause();
    test_full_rate(150);
    wait_drained();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // output stall bursts while idle_on is set, with quiet stretches between them
  initial begin
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
        @(posedge clk);
      if (idle_on) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    hsv_t want;
    if (!rst && out_valid && !out_stall) begin
      if (hsv_due.size() == 0) begin
        $error("result with no request pending: value %0d sat %0d hue %0d",
               value_out, saturation_out, hue_out);
        mismatches++;
      end else begin
        want = hsv_due.pop_front();
        if (value_out !== want.value) begin
          $error("value_out expected %0d actual %0d", want.value, value_out);
          mismatches++;
        end
        if (saturation_out !== want.sat) begin
          $error("saturation_out expected %0d actual %0d", want.sat, saturation_out);
          mismatches++;
        end
        if (hue_out !== want.hue) begin
          $error("hue_out expected %0d actual %0d", want.hue, hue_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
